// File: sv/lnc_pkg.sv
// ============================================================================
// lnc_pkg: shared types and constants for the LFU name cache
// Word formats, scan pipeline records and sequencer states.
// ============================================================================
package lnc_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_BITS   = 64;
    localparam int ADDR_BITS  = 32;
    localparam int ERR_BITS   = 16;
    localparam int SLOT_BITS  = 4;

    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [ERR_BITS-1:0]   err_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;

    localparam idx_t   LAST_IDX  = idx_t'(ENTRIES - 1);
    localparam count_t COUNT_MAX = '1;

    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // request word
    typedef struct packed {
        op_t   opcode;
        key_t  key;
        addr_t new_address;
        err_t  new_error;
    } req_word_t;

    // response word
    typedef struct packed {
        logic  hit;
        addr_t address;
        err_t  error_code;
        slot_t slot;
    } rsp_word_t;

    // one entry as read out of the store
    typedef struct packed {
        logic   valid;
        idx_t   idx;
        key_t   key;
        addr_t  address;
        err_t   error;
        count_t count;
    } rd_word_t;

    // store write request
    typedef struct packed {
        logic   data_we;
        logic   cnt_we;
        idx_t   idx;
        key_t   key;
        addr_t  address;
        err_t   error;
        count_t count;
    } wr_word_t;

    // accumulated scan outcome
    typedef struct packed {
        logic   found;
        idx_t   idx;
        addr_t  address;
        err_t   error;
        count_t count;
    } scan_res_t;

endpackage

// File: sv/lnc_store.sv
// ============================================================================
// lnc_store: entry storage
// Key/address/error memories with a registered read port, plus use counts
// in flops cleared by reset (count zero marks a free entry).
// ============================================================================
module lnc_store (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  lnc_pkg::idx_t    rd_idx,
    input  lnc_pkg::wr_word_t wr,
    output lnc_pkg::rd_word_t rd
);
    import lnc_pkg::*;

    key_t   key_mem  [ENTRIES];
    addr_t  addr_mem [ENTRIES];
    err_t   err_mem  [ENTRIES];
    count_t cnt_reg  [ENTRIES];

    logic   rd_valid_reg;
    idx_t   rd_idx_reg;
    key_t   rd_key_reg;
    addr_t  rd_addr_reg;
    err_t   rd_err_reg;
    count_t rd_cnt_reg;

    // data memories, no reset
    always_ff @(posedge clk)
    begin
        if (wr.data_we)
        begin
            key_mem[wr.idx]  <= wr.key;
            addr_mem[wr.idx] <= wr.address;
            err_mem[wr.idx]  <= wr.error;
        end
        if (rd_en)
        begin
            rd_idx_reg  <= rd_idx;
            rd_key_reg  <= key_mem[rd_idx];
            rd_addr_reg <= addr_mem[rd_idx];
            rd_err_reg  <= err_mem[rd_idx];
            rd_cnt_reg  <= cnt_reg[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                cnt_reg[i] <= '0;
            end
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.cnt_we)
            begin
                cnt_reg[wr.idx] <= wr.count;
            end
            rd_valid_reg <= rd_en;
        end
    end

    assign rd.valid   = rd_valid_reg;
    assign rd.idx     = rd_idx_reg;
    assign rd.key     = rd_key_reg;
    assign rd.address = rd_addr_reg;
    assign rd.error   = rd_err_reg;
    assign rd.count   = rd_cnt_reg;

endmodule

// File: sv/lnc_match.sv
// ============================================================================
// lnc_match: shared compare unit
// Sees one entry per cycle; keeps the first key match (lookup) or the
// first free / least-used entry (insert).
// ============================================================================
module lnc_match (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lnc_pkg::op_t      op,
    input  lnc_pkg::key_t     key,
    input  lnc_pkg::rd_word_t rd,
    output lnc_pkg::scan_res_t res
);
    import lnc_pkg::*;

    logic   found_reg;
    idx_t   idx_reg;
    addr_t  addr_reg;
    err_t   err_reg;
    count_t cnt_reg;

    logic   occupied;
    logic   key_eq;
    logic   cnt_lt;

    assign occupied = (rd.count != '0);
    assign key_eq   = (rd.key == key);
    assign cnt_lt   = (rd.count < cnt_reg) || (rd.idx == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (start)
        begin
            found_reg <= 1'b0;
        end
        else if (rd.valid && !found_reg)
        begin
            if (op == OP_LOOKUP)
            begin
                found_reg <= occupied && key_eq;
            end
            else
            begin
                found_reg <= !occupied;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            idx_reg <= '0;
        end
        else if (rd.valid && !found_reg)
        begin
            if (op == OP_LOOKUP)
            begin
                if (occupied && key_eq)
                begin
                    idx_reg  <= rd.idx;
                    addr_reg <= rd.address;
                    err_reg  <= rd.error;
                    cnt_reg  <= rd.count;
                end
            end
            else if (!occupied || cnt_lt)
            begin
                // free entry ends the search; otherwise track lowest count
                idx_reg <= rd.idx;
                cnt_reg <= rd.count;
            end
        end
    end

    assign res.found   = found_reg;
    assign res.idx     = idx_reg;
    assign res.address = addr_reg;
    assign res.error   = err_reg;
    assign res.count   = cnt_reg;

endmodule

// File: sv/lfu_name_cache_top.sv
// ============================================================================
// lfu_name_cache_top: fully associative name cache with LFU replacement
// Sequencer, request/response registers and write-back of one entry.
// ============================================================================
// Usage:
//   req channel (req_valid / req_stall / req) carries one word: opcode, key,
//   new_address, new_error. Lookup returns hit, address, error code and the
//   slot hit; insert writes the first free entry, or the least-used one
//   (lowest index on ties), and returns the slot written.
//   rsp channel (rsp_valid / rsp_stall / rsp) carries one word per request.
//   Scan: the entries are read one per cycle through the store's single
//   read port and fed to a shared compare unit; a word then passes ST_DRAIN
//   and ST_DONE before it is loaded into the rsp register.
//   A new request is taken only after the last one has finished; req_stall
//   stays high while a word is being scanned.
//   A finished response sits in the rsp register; the next request is taken
//   while it waits. If the rsp register is still full when the next scan
//   ends, the block holds in its final state until rsp_stall drops.
//   Reset clears all use counts at once (all entries free) and empties the
//   rsp register; no clearing pass is needed.
// ============================================================================
module lfu_name_cache_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  lnc_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output lnc_pkg::rsp_word_t rsp
);
    import lnc_pkg::*;

    state_t    state_reg, state_next;
    idx_t      idx_reg, idx_next;
    req_word_t req_reg;
    rsp_word_t rsp_reg, rsp_next;
    logic      rsp_valid_reg, rsp_valid_next;

    logic      accept;
    logic      rd_en;
    logic      scan_start;
    logic      finish;
    logic      rsp_free;

    rd_word_t  rd;
    wr_word_t  wr;
    scan_res_t res;

    assign accept   = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // --- sequencer: next state ---
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // --- sequencer: outputs ---
    always_comb
    begin
        req_stall  = 1'b1;
        rd_en      = 1'b0;
        scan_start = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                scan_start = req_valid;
            end
            ST_SCAN:
            begin
                rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                rd_en = 1'b0;
            end
            ST_DONE:
            begin
                finish = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // --- entry write-back on finish ---
    always_comb
    begin
        wr.data_we = finish && (req_reg.opcode == OP_INSERT);
        wr.cnt_we  = finish && ((req_reg.opcode == OP_INSERT) ||
                                (res.found && (res.count != COUNT_MAX)));
        wr.idx     = res.idx;
        wr.key     = req_reg.key;
        wr.address = req_reg.new_address;
        wr.error   = req_reg.new_error;
        wr.count   = (req_reg.opcode == OP_INSERT) ? count_t'(1) : res.count + 1'b1;
    end

    // --- response word ---
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (finish)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            if (req_reg.opcode == OP_INSERT)
            begin
                rsp_next.slot = slot_t'(res.idx);
            end
            else if (res.found)
            begin
                rsp_next.hit        = 1'b1;
                rsp_next.address    = res.address;
                rsp_next.error_code = res.error;
                rsp_next.slot       = slot_t'(res.idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    lnc_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (rd_en),
        .rd_idx (idx_reg),
        .wr     (wr),
        .rd     (rd)
    );

    lnc_match u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .op    (req_reg.opcode),
        .key   (req_reg.key),
        .rd    (rd),
        .res   (res)
    );

    // --- checks ---
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response loaded outside final state");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.hit) |-> (rsp_reg.address == '0 &&
                                             rsp_reg.error_code == '0))
        else $error("miss or insert response carries data");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && idx_reg == LAST_IDX) |=> (state_reg == ST_DRAIN))
        else $error("scan did not end after last entry");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (rd.valid || state_reg == ST_DONE) |-> req_stall)
        else $error("request taken during scan");

endmodule
